>>> rtl/core/hcle_pkg.sv
// Shared types and constants for the Content-Length header extractor.
`timescale 1ns / 1ps

package hcle_pkg;

    localparam int unsigned KeyLen = 16;
    localparam int unsigned KeyPosW = $clog2(KeyLen + 1);
    localparam int unsigned KeyIdxW = $clog2(KeyLen);

    localparam logic [7:0] KEY_TEXT [KeyLen] = '{
        8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
        8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a, 8'h20
    };

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0b;
    localparam logic [7:0] CHAR_FF    = 8'h0c;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_C     = 8'h43;

    localparam logic [31:0] POS_LIMIT = 32'h7fff_ffff;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [3:0] {
        SCAN_KEY   = 4'b0001,
        SCAN_VALUE = 4'b0010,
        SCAN_DONE  = 4'b0100,
        SCAN_NONE  = 4'b1000
    } t_scan_phase;

    typedef enum logic [2:0] {
        NUM_SKIP   = 3'b001,
        NUM_DIGITS = 3'b010,
        NUM_STOP   = 3'b100
    } t_num_phase;

    typedef struct packed {
        t_num_phase  phase;
        logic        neg;
        logic [31:0] mag;
        logic        ovf;
    } t_num_state;

    localparam t_num_state NUM_RESET = '{
        phase: NUM_SKIP, neg: 1'b0, mag: 32'd0, ovf: 1'b0
    };

endpackage

>>> rtl/core/hcle_num.sv
// Decimal value decoder step: whitespace skip, sign, digit accumulate with saturation.
`timescale 1ns / 1ps

module hcle_num (
    input  logic [7:0]          i_char,
    input  hcle_pkg::t_num_state i_cur,
    output hcle_pkg::t_num_state o_next
);
    import hcle_pkg::*;

    logic        is_blank;
    logic        is_sign;
    logic        is_digit;
    logic [35:0] prod;
    logic [35:0] limit;
    logic        over;

    assign is_blank = (i_char == CHAR_SPACE) || (i_char == CHAR_TAB) ||
                      (i_char == CHAR_VT) || (i_char == CHAR_FF) || (i_char == CHAR_CR);
    assign is_sign  = (i_char == CHAR_PLUS) || (i_char == CHAR_MINUS);
    assign is_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);

    assign prod  = ({4'd0, i_cur.mag} << 3) + ({4'd0, i_cur.mag} << 1)
                 + {32'd0, i_char[3:0]};
    assign limit = {4'd0, (i_cur.neg ? NEG_LIMIT : POS_LIMIT)};
    assign over  = prod > limit;

    always_comb begin
        o_next = i_cur;
        case (i_cur.phase)
            NUM_SKIP: begin
                if (is_blank) begin
                    o_next = i_cur;
                end else if (is_sign) begin
                    o_next.neg   = (i_char == CHAR_MINUS);
                    o_next.phase = NUM_DIGITS;
                end else if (is_digit) begin
                    o_next.mag   = over ? limit[31:0] : prod[31:0];
                    o_next.ovf   = i_cur.ovf | over;
                    o_next.phase = NUM_DIGITS;
                end else begin
                    o_next.phase = NUM_STOP;
                end
            end
            NUM_DIGITS: begin
                if (is_digit) begin
                    o_next.mag = over ? limit[31:0] : prod[31:0];
                    o_next.ovf = i_cur.ovf | over;
                end else begin
                    o_next.phase = NUM_STOP;
                end
            end
            default: begin
                o_next = i_cur;
            end
        endcase
    end

endmodule

>>> rtl/core/http_content_length_extractor.sv
// Top level of the Content-Length header extractor.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_header_byte, i_last_byte
// result    out        o_valid / i_stall  o_length_found, o_length_value, o_value_saturated
//
// One header byte is taken per cycle when not stalled; the match, sign and multiply-by-ten
// update of the parser state all complete in the cycle the beat is accepted.
// A result beat appears in the cycle after the beat flagged last is accepted.
// Input is stalled only while a result is held and the result side is stalled.
// Reset returns the parser to pattern search and empties the result register.
module http_content_length_extractor #(
    parameter int unsigned MAX_VALUE_CHARS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_header_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_length_found,
    output logic signed [31:0] o_length_value,
    output logic               o_value_saturated
);
    import hcle_pkg::*;

    localparam int unsigned CntW = $clog2(MAX_VALUE_CHARS + 1);

    t_scan_phase          r_scan, n_scan;
    logic [KeyPosW-1:0]   r_pos, n_pos;
    logic [CntW-1:0]      r_cnt, n_cnt;
    t_num_state           r_num, n_num;
    t_num_state           num_step;
    logic                 r_out_valid;
    logic                 r_found;
    logic [31:0]          r_value;
    logic                 r_sat;
    logic                 accept;
    logic                 found;
    logic [KeyPosW-1:0]   pos_inc;
    logic [CntW-1:0]      cnt_inc;

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    hcle_num u_num (
        .i_char (i_header_byte),
        .i_cur  (r_num),
        .o_next (num_step)
    );

    assign pos_inc = r_pos + 1'b1;
    assign cnt_inc = r_cnt + 1'b1;

    always_comb begin
        n_scan = r_scan;
        n_pos  = r_pos;
        n_cnt  = r_cnt;
        n_num  = r_num;
        case (r_scan)
            SCAN_KEY: begin
                if (i_header_byte == CHAR_NUL) begin
                    n_scan = SCAN_NONE;
                end else if (!r_pos[KeyPosW-1] &&
                             i_header_byte == KEY_TEXT[r_pos[KeyIdxW-1:0]]) begin
                    n_pos = pos_inc;
                    if (pos_inc == KeyPosW'(KeyLen)) begin
                        n_scan = SCAN_VALUE;
                    end
                end else begin
                    n_pos = (i_header_byte == CHAR_C) ? KeyPosW'(1) : '0;
                end
            end
            SCAN_VALUE: begin
                if (i_header_byte == CHAR_NUL || i_header_byte == CHAR_LF) begin
                    n_scan = SCAN_DONE;
                end else begin
                    n_num = num_step;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= CntW'(MAX_VALUE_CHARS)) begin
                        n_scan = SCAN_DONE;
                    end
                end
            end
            default: begin
                n_scan = r_scan;
            end
        endcase
    end

    assign found = (n_scan == SCAN_VALUE) || (n_scan == SCAN_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= SCAN_KEY;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_num       <= NUM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last_byte) begin
                    r_scan <= SCAN_KEY;
                    r_pos  <= '0;
                    r_cnt  <= '0;
                    r_num  <= NUM_RESET;
                end else begin
                    r_scan <= n_scan;
                    r_pos  <= n_pos;
                    r_cnt  <= n_cnt;
                    r_num  <= n_num;
                end
            end
            if (accept && i_last_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_found <= found;
            r_sat   <= found & n_num.ovf;
            if (!found) begin
                r_value <= 32'd0;
            end else if (n_num.neg) begin
                r_value <= 32'd0 - n_num.mag;
            end else begin
                r_value <= n_num.mag;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_length_found    = r_found;
    assign o_length_value    = r_value;
    assign o_value_saturated = r_sat;

endmodule

>>> dv/http_content_length_extractor_tb.sv
// Self-checking testbench for the Content-Length header extractor.
`timescale 1ns / 1ps

module http_content_length_extractor_tb;

    import hcle_pkg::*;

    localparam int MAX_CHARS       = 20;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic               found;
        logic signed [31:0] value;
        logic               sat;
    } t_len_result;

    typedef struct {
        string       text;
        int          nul_at;
        bit          typed;
        t_len_result res;
    } t_hdr_case;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_header_byte = 8'h00;
    logic               i_last_byte = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_length_found;
    logic signed [31:0] o_length_value;
    logic               o_value_saturated;

    // Predicted parser state.
    t_scan_phase scan_st;
    t_num_phase  num_st;
    int unsigned key_pos;
    int unsigned val_chars;
    logic        neg;
    logic [31:0] mag;
    logic        ovf;

    t_len_result expected_lengths[$];
    logic [7:0]  hdr_bytes[$];
    t_len_result want;
    t_len_result got;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          bytes_sent = 0;
    int          stall_left = 0;
    int          stall_roll = 0;
    bit          steady_in = 1'b0;
    bit          steady_out = 1'b0;

    t_hdr_case dir_cases[20] = '{
        '{"HTTP/1.1 200 OK\015\n", -1, 1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{"Content-Length: 1234\015\n", -1, 1'b1, '{1'b1, 32'sd1234, 1'b0}},
        '{"Content-Length: 2147483647\n", -1, 1'b1, '{1'b1, 32'h7fff_ffff, 1'b0}},
        '{"Content-Length: 99999999999\n", -1, 1'b1, '{1'b1, 32'h7fff_ffff, 1'b1}},
        '{"Content-Length: -2147483648\n", -1, 1'b1, '{1'b1, 32'h8000_0000, 1'b0}},
        '{"Content-Length: -2147483649\n", -1, 1'b1, '{1'b1, 32'h8000_0000, 1'b1}},
        '{"Content-Length: ", -1, 1'b1, '{1'b1, 32'sd0, 1'b0}},
        '{"?", 0, 1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{"AB_Content-Length: 3", 2, 1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{"content-length: 10", -1, 1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{"Server: x\nCContent-Length: 77\n", -1, 1'b0, '0},
        '{"Content-LengtContent-Length: 8", -1, 1'b0, '0},
        '{"Content-Length: \t\013\014\015 +0042xyz", -1, 1'b0, '0},
        '{"Content-Length:   -12345678901234567890123", -1, 1'b0, '0},
        '{"Content-Length: 5\n6", -1, 1'b0, '0},
        '{"Content-Length: 9_9", 17, 1'b0, '0},
        '{"Content-Length: +-5", -1, 1'b0, '0},
        '{"Content-Length: \377\200 1", -1, 1'b0, '0},
        '{"Content-Length: 1\n Content-Length: 2", -1, 1'b0, '0},
        '{"Content-Length: 00000000000000000000009", -1, 1'b0, '0}
    };

    http_content_length_extractor #(
        .MAX_VALUE_CHARS(MAX_CHARS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_header_byte    (i_header_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_length_found   (o_length_found),
        .o_length_value   (o_length_value),
        .o_value_saturated(o_value_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF ||
               c == CHAR_CR;
    endfunction

    task automatic clear_parser();
        scan_st   = SCAN_KEY;
        num_st    = NUM_SKIP;
        key_pos   = 0;
        val_chars = 0;
        neg       = 1'b0;
        mag       = 32'd0;
        ovf       = 1'b0;
    endtask

    task automatic feed_number(input logic [7:0] c);
        logic [35:0] nxt;
        logic [31:0] lim;
        if (num_st == NUM_SKIP && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            neg    = (c == CHAR_MINUS);
            num_st = NUM_DIGITS;
        end else if (num_st != NUM_STOP && !(num_st == NUM_SKIP && is_blank(c))) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                lim = neg ? NEG_LIMIT : POS_LIMIT;
                nxt = {4'd0, mag} * 36'd10 + {28'd0, c} - {28'd0, CHAR_ZERO};
                if (nxt > {4'd0, lim}) begin
                    nxt = {4'd0, lim};
                    ovf = 1'b1;
                end
                mag    = nxt[31:0];
                num_st = NUM_DIGITS;
            end else begin
                num_st = NUM_STOP;
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] c);
        case (scan_st)
            SCAN_KEY: begin
                if (c == CHAR_NUL) begin
                    scan_st = SCAN_NONE;
                end else if (key_pos < KeyLen && c == KEY_TEXT[key_pos]) begin
                    key_pos++;
                    if (key_pos >= KeyLen) begin
                        scan_st = SCAN_VALUE;
                    end
                end else begin
                    key_pos = (c == CHAR_C) ? 1 : 0;
                end
            end
            SCAN_VALUE: begin
                if (c == CHAR_NUL || c == CHAR_LF) begin
                    scan_st = SCAN_DONE;
                end else begin
                    feed_number(c);
                    val_chars++;
                    if (val_chars >= MAX_CHARS) begin
                        scan_st = SCAN_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic close_header(output t_len_result res);
        res.found = (scan_st == SCAN_VALUE || scan_st == SCAN_DONE);
        res.value = res.found ? (neg ? -mag : mag) : 32'sd0;
        res.sat   = res.found && ovf;
        clear_parser();
    endtask

    function automatic int pick_send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_in || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        b = ($urandom_range(0, 3) == 0) ? CHAR_C : 8'($urandom_range(32, 126));
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_VT;
            3: return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    task automatic send_header(input bit use_typed, input t_len_result typed_res);
        int          gap;
        t_len_result pred;
        for (int i = 0; i < hdr_bytes.size(); i++) begin
            gap = pick_send_gap();
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid       <= 1'b1;
            i_header_byte <= hdr_bytes[i];
            i_last_byte   <= (i == hdr_bytes.size() - 1);
            @(negedge i_clk);
            while (o_stall) @(negedge i_clk);
            @(posedge i_clk);
            bytes_sent++;
            parse_byte(hdr_bytes[i]);
            if (i == hdr_bytes.size() - 1) begin
                close_header(pred);
                expected_lengths.push_back(use_typed ? typed_res : pred);
            end
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_lengths.size() != 0) @(posedge i_clk);
    endtask

    task automatic build_random_header();
        int          kind;
        int          n;
        int          style;
        int unsigned u;
        string       txt;
        txt = "";
        hdr_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            n = $urandom_range(1, 8);
            repeat (n) hdr_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 3)) hdr_bytes.push_back(pick_text_byte());
            if (kind < 25) begin
                n = $urandom_range(1, KeyLen - 1);
                for (int i = 0; i < n; i++) hdr_bytes.push_back(KEY_TEXT[i]);
            end
            for (int i = 0; i < KeyLen; i++) hdr_bytes.push_back(KEY_TEXT[i]);
            if (kind < 35) begin
                hdr_bytes[hdr_bytes.size() - 1 - $urandom_range(0, KeyLen - 1)] =
                    8'($urandom_range(0, 255));
            end
            if (kind < 95) begin
                repeat ($urandom_range(0, 2)) hdr_bytes.push_back(pick_blank());
                case ($urandom_range(0, 3))
                    1: hdr_bytes.push_back(CHAR_PLUS);
                    2: hdr_bytes.push_back(CHAR_MINUS);
                    default: begin
                    end
                endcase
                style = $urandom_range(0, 9);
                if (style < 5) begin
                    txt = $sformatf("%0d", $urandom_range(0, 99999));
                end else if (style < 7) begin
                    u   = $urandom();
                    txt = $sformatf("%0d", u);
                end else if (style < 8) begin
                    u   = 32'd2147483646 + $urandom_range(0, 3);
                    txt = $sformatf("%0d", u);
                end else begin
                    repeat ($urandom_range(11, 24)) begin
                        hdr_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                    end
                end
                for (int i = 0; i < txt.len(); i++) hdr_bytes.push_back(txt[i]);
                case ($urandom_range(0, 5))
                    1: begin
                        hdr_bytes.push_back(CHAR_CR);
                        hdr_bytes.push_back(CHAR_LF);
                    end
                    2: begin
                        hdr_bytes.push_back(CHAR_LF);
                        repeat (3) hdr_bytes.push_back(pick_text_byte());
                    end
                    3: hdr_bytes.push_back(8'($urandom_range(0, 255)));
                    4: begin
                        hdr_bytes.push_back(CHAR_NUL);
                        hdr_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    5: begin
                        hdr_bytes.push_back(CHAR_CR);
                        hdr_bytes.push_back(CHAR_LF);
                        repeat (2) hdr_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    default: begin
                    end
                endcase
            end
        end
    endtask

    task automatic note_mismatch(input string what, input t_len_result exp_res,
                                 input t_len_result act_res);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%t: %s: expected found=%0b value=%0d sat=%0b, got found=%0b value=%0d sat=%0b",
                     $realtime, what, exp_res.found, exp_res.value, exp_res.sat,
                     act_res.found, act_res.value, act_res.sat);
        end
    endtask

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            steady_out = !steady_out;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_left == 0 && !steady_out) begin
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 65) begin
                    stall_left = 0;
                end else if (stall_roll < 93) begin
                    stall_left = $urandom_range(1, 3);
                end else begin
                    stall_left = $urandom_range(8, 40);
                end
            end
            i_stall <= (stall_left != 0);
            if (stall_left != 0) begin
                stall_left--;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (o_valid && !i_stall) begin
                got = '{o_length_found, o_length_value, o_value_saturated};
                if (expected_lengths.size() == 0) begin
                    note_mismatch("result beat with none expected", '0, got);
                end else begin
                    want = expected_lengths.pop_front();
                    if (got.found !== want.found || got.value !== want.value ||
                        got.sat !== want.sat) begin
                        note_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        clear_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_cases[k]) begin
            hdr_bytes.delete();
            for (int i = 0; i < dir_cases[k].text.len(); i++) begin
                hdr_bytes.push_back((i == dir_cases[k].nul_at) ? CHAR_NUL : dir_cases[k].text[i]);
            end
            send_header(dir_cases[k].typed, dir_cases[k].res);
        end
        wait_for_results();

        while (bytes_sent < 600) begin
            if ($urandom_range(0, 19) == 0) begin
                wait_for_results();
            end
            if ($urandom_range(0, 9) == 0) begin
                steady_in = !steady_in;
            end
            build_random_header();
            send_header(1'b0, '0);
        end

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_lengths.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
